/* rtl/sml_pkg.sv */
// ----------------------------------------------------------------------------
// sml_pkg: shared types and constants for the static MAC/IP lease table
// Table size, opcode values, entry layout and the structs passed between the
// search engine, the entry memory and the top level.
// ----------------------------------------------------------------------------
package sml_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int OP_W   = 2;
   localparam int HW_W   = 48;
   localparam int NET_W  = 32;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

   // One stored binding
   typedef struct packed {
      logic [HW_W-1:0]  hw;
      logic [NET_W-1:0] net;
   } sml_entry_type;

   // Memory access from the engine
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_index;
      sml_entry_type    wr_data;
      logic [IDX_W-1:0] rd_index;
   } sml_ram_req_type;

   // One result word
   typedef struct packed {
      logic [NET_W-1:0] found_address;
      logic             hit;
      logic             status;
   } sml_result_type;

endpackage

/* rtl/sml_ram.sv */
// ----------------------------------------------------------------------------
// sml_ram: binding storage
// Single write port, single read port with a registered read; one entry per
// binding, no reset on the contents.
// ----------------------------------------------------------------------------
module sml_ram (
   input  logic                     clock,
   input  sml_pkg::sml_ram_req_type ram_req,
   output sml_pkg::sml_entry_type   rd_data
);
   import sml_pkg::*;

   sml_entry_type mem [TABLE_DEPTH];
   sml_entry_type rd_data_ff;

   // Write the new binding
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_index] <= ram_req.wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.rd_index];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sml_engine.sv */
// ----------------------------------------------------------------------------
// sml_engine: command sequencer for the lease table
// Appends bindings, and walks the stored entries one per cycle from the
// oldest for lookups and reserved checks, stopping at the first match.
// ----------------------------------------------------------------------------
module sml_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sml_pkg::OP_W-1:0]      req_op,
   input  logic [sml_pkg::HW_W-1:0]      req_hw,
   input  logic [sml_pkg::NET_W-1:0]     req_net,
   output sml_pkg::sml_ram_req_type      ram_req,
   input  sml_pkg::sml_entry_type        ram_rd_data,
   output logic                          res_valid,
   input  logic                          res_ready,
   output sml_pkg::sml_result_type       res
);
   import sml_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]       state_ff,  state_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [IDX_W-1:0] cur_ff,    cur_in;
   logic [OP_W-1:0]  op_ff,     op_in;
   logic [HW_W-1:0]  hw_ff,     hw_in;
   logic [NET_W-1:0] net_ff,    net_in;
   sml_result_type   res_ff,    res_in;

   logic             match;
   logic             last;

   // Compare the word read for the current entry
   assign match = (op_ff == OP_LOOKUP) ? (ram_rd_data.hw == hw_ff)
                                       : (ram_rd_data.net == net_ff);
   assign last  = ((CNT_W'(cur_ff) + CNT_W'(1)) == count_ff);

   // Sequence one command at a time
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      op_in    = op_ff;
      hw_in    = hw_ff;
      net_in   = net_ff;
      res_in   = res_ff;

      req_ready        = 1'b0;
      res_valid        = 1'b0;
      ram_req.wr_en    = 1'b0;
      ram_req.wr_index = count_ff[IDX_W-1:0];
      ram_req.wr_data  = '{hw: req_hw, net: req_net};
      ram_req.rd_index = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = req_op;
               hw_in  = req_hw;
               net_in = req_net;
               cur_in = '0;
               res_in = '0;
               unique case (req_op)
                  OP_ADD: begin
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        ram_req.wr_en = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        res_in.status = 1'b1;
                     end
                     state_in = ST_FINISH;
                  end
                  OP_LOOKUP, OP_CHECK: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Fetch the next entry while judging the current one
            ram_req.rd_index = cur_ff + IDX_W'(1);
            if (match) begin
               res_in.hit           = 1'b1;
               res_in.found_address = (op_ff == OP_LOOKUP) ? ram_rd_data.net : '0;
               state_in             = ST_FINISH;
            end else if (last) begin
               state_in = ST_FINISH;
            end else begin
               cur_in = cur_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Command and result payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      op_ff  <= op_in;
      hw_ff  <= hw_in;
      net_ff <= net_in;
      res_ff <= res_in;
   end

   assign res = res_ff;

`ifndef ASSERT_OFF
   // Entry count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // Count moves only by an accepted add
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == ST_IDLE && $past(req_valid) && $past(req_op) == OP_ADD
          && count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("entry count changed without an add");

   // A scan never walks past the stored entries
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(cur_ff) < count_ff))
      else $error("scan index beyond stored entries");

   // A full table rejects an add
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_op == OP_ADD
       && count_ff == CNT_W'(TABLE_DEPTH)) |=> res_ff.status)
      else $error("add into full table not rejected");
`endif

endmodule

/* rtl/static_mac_ip_lease_table.sv */
// ----------------------------------------------------------------------------
// static_mac_ip_lease_table: table of reserved MAC/IPv4 bindings
// Top level: stream ports, the search engine, the entry memory and the
// result output register.
// ----------------------------------------------------------------------------
// Handles one command at a time and returns exactly one result word per
// command. An add, a rejected add, an unused opcode, or a search of an empty
// table goes from acceptance straight to the finish state. A lookup or
// reserved check walks the stored entries through the single read port of
// the entry memory, one entry per cycle from the oldest, and stops at the
// first matching entry or after the last stored entry. A finished result
// sits in an output register, so the next command is taken while it waits.
// ----------------------------------------------------------------------------
module static_mac_ip_lease_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // [47:0] hw_address, [79:48] net_address
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] found_address
   output logic [1:0]  rsp_tuser    // [0] hit, [1] status
);
   import sml_pkg::*;

   sml_ram_req_type ram_req;
   sml_entry_type   ram_rd_data;
   sml_result_type  res;
   logic            res_valid;
   logic            res_ready;

   logic            rsp_valid_ff, rsp_valid_in;
   sml_result_type  rsp_data_ff;

   sml_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_hw      (req_tdata[HW_W-1:0]),
      .req_net     (req_tdata[HW_W+NET_W-1:HW_W]),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   sml_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // Load the output register when it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.found_address;
   assign rsp_tuser  = {rsp_data_ff.status, rsp_data_ff.hit};

endmodule

/* sim/lease_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lease_table_checker: scoreboard for the static MAC/IP lease table
// Watches the command and result streams, keeps its own copy of the binding
// table, predicts one result word per accepted command and compares every
// accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module lease_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,   // [47:0] hw_address, [79:48] net_address
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] found_address
   input  logic [1:0]  rsp_tuser,   // [0] hit, [1] status
   output int          fail_count,
   output int          outstanding
);
   import sml_pkg::*;

   // Shadow copy of the binding table
   logic [HW_W-1:0]  bound_hw  [TABLE_DEPTH];
   logic [NET_W-1:0] bound_net [TABLE_DEPTH];
   int               binding_count;

   // Predicted result words, oldest first
   sml_result_type   pending_results [$];

   // Apply one command to the shadow table and return its result word
   function automatic sml_result_type apply_command(input logic [OP_W-1:0]  op,
                                                    input logic [HW_W-1:0]  hw,
                                                    input logic [NET_W-1:0] net);
      sml_result_type res;
      res = '0;
      case (op)
         OP_ADD: begin
            if (binding_count < TABLE_DEPTH) begin
               bound_hw[binding_count]  = hw;
               bound_net[binding_count] = net;
               binding_count++;
            end else begin
               res.status = 1'b1;
            end
         end
         // first (oldest) match wins
         OP_LOOKUP: begin
            for (int i = 0; i < binding_count; i++) begin
               if (!res.hit && bound_hw[i] == hw) begin
                  res.hit           = 1'b1;
                  res.found_address = bound_net[i];
               end
            end
         end
         OP_CHECK: begin
            for (int i = 0; i < binding_count; i++) begin
               if (bound_net[i] == net) res.hit = 1'b1;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Compare result words first, then record the new command
   always @(posedge clock) begin : scoreboard
      sml_result_type want;
      sml_result_type got;
      int             errs;
      errs = 0;
      if (reset) begin
         binding_count = 0;
         pending_results.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found_address = rsp_tdata;
            got.hit           = rsp_tuser[0];
            got.status        = rsp_tuser[1];
            if (pending_results.size() == 0) begin
               $error("result word with none pending: found_address %h hit %b status %b",
                      got.found_address, got.hit, got.status);
               errs++;
            end else begin
               want = pending_results.pop_front();
               if (got.found_address !== want.found_address) begin
                  $error("found_address: expected %h, got %h",
                         want.found_address, got.found_address);
                  errs++;
               end
               if (got.hit !== want.hit) begin
                  $error("hit: expected %b, got %b", want.hit, got.hit);
                  errs++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %b, got %b", want.status, got.status);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(apply_command(req_tuser, req_tdata[47:0],
                                                    req_tdata[79:48]));
         end
         fail_count  <= fail_count + errs;
         outstanding <= pending_results.size();
      end
   end

endmodule

/* sim/tb_static_mac_ip_lease_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_static_mac_ip_lease_table: testbench for the static MAC/IP lease table
// Drives directed and random add, lookup, reserved-check and unused-opcode
// commands with random idle bursts on both streams; the scoreboard module
// predicts and checks every result word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_static_mac_ip_lease_table;
   import sml_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 620;
   localparam int CALM_FROM    = 520;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;   // [47:0] hw_address, [79:48] net_address
   logic [1:0]  req_tuser  = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;         // [31:0] found_address
   logic [1:0]  rsp_tuser;         // [0] hit, [1] status

   int          fail_count;
   int          outstanding;
   logic        idle_enable = 1'b0;
   int          stall_left  = 0;

   // Bindings accepted so far, and small pools that make duplicates likely
   logic [HW_W-1:0]  added_hw  [$];
   logic [NET_W-1:0] added_net [$];
   logic [HW_W-1:0]  hw_pool   [4];
   logic [NET_W-1:0] net_pool  [4];

   static_mac_ip_lease_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lease_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Clock: 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result-side stalls: random bursts with tready low
   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [HW_W-1:0] rand_hw();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[HW_W-1:0];
   endfunction

   // Hardware address for a lookup or add: mostly stored ones, some near misses
   function automatic logic [HW_W-1:0] pick_hw();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 5 && added_hw.size() != 0)
         return added_hw[$urandom_range(0, added_hw.size() - 1)];
      if (sel <= 7)
         return hw_pool[$urandom_range(0, 3)];
      if (sel == 8 && added_hw.size() != 0)
         return added_hw[$urandom_range(0, added_hw.size() - 1)]
                ^ (48'd1 << $urandom_range(0, HW_W - 1));
      return rand_hw();
   endfunction

   function automatic logic [NET_W-1:0] pick_net();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 5 && added_net.size() != 0)
         return added_net[$urandom_range(0, added_net.size() - 1)];
      if (sel <= 7)
         return net_pool[$urandom_range(0, 3)];
      if (sel == 8 && added_net.size() != 0)
         return added_net[$urandom_range(0, added_net.size() - 1)]
                ^ (32'd1 << $urandom_range(0, NET_W - 1));
      return $urandom;
   endfunction

   // Send one command word, with an optional idle burst ahead of it
   task automatic issue_command(input logic [OP_W-1:0]  op,
                                input logic [HW_W-1:0]  hw,
                                input logic [NET_W-1:0] net);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {net, hw};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      if (op == OP_ADD && added_hw.size() < TABLE_DEPTH) begin
         added_hw.push_back(hw);
         added_net.push_back(net);
      end
   endtask

   // Hold off the sender until every pending result word is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Stimulus and verdict
   initial begin
      int r;
      int wait_cycles;
      hw_pool[0]  = '0;
      hw_pool[1]  = '1;
      hw_pool[2]  = rand_hw();
      hw_pool[3]  = rand_hw();
      net_pool[0] = '0;
      net_pool[1] = '1;
      net_pool[2] = $urandom;
      net_pool[3] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, zero binding, duplicates, unused opcode
      issue_command(OP_LOOKUP, '0, '0);
      issue_command(OP_CHECK,  '1, '1);
      issue_command(OP_UNUSED, '1, '1);
      issue_command(OP_ADD,    '1, '1);
      issue_command(OP_ADD,    '0, '0);
      issue_command(OP_ADD,    '1, 32'h0A00_0001);
      issue_command(OP_LOOKUP, '1, '0);
      issue_command(OP_LOOKUP, '0, '1);
      issue_command(OP_LOOKUP, 48'h0000_0000_0001, '0);
      issue_command(OP_CHECK,  '0, '0);
      issue_command(OP_CHECK,  '0, 32'h0A00_0001);
      issue_command(OP_CHECK,  '0, 32'hFFFF_FFFE);
      issue_command(OP_UNUSED, '0, '0);
      issue_command(OP_ADD,    48'h8000_0000_0000, 32'h8000_0000);
      issue_command(OP_LOOKUP, 48'h8000_0000_0000, '0);
      issue_command(OP_CHECK,  '1, 32'h7FFF_FFFF);
      drain_results();

      // Random: adds are sparse so the table fills around mid-run
      idle_enable <= 1'b1;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == CALM_FROM) idle_enable <= 1'b0;
         if (n == 200 || n == 400) drain_results();
         r = $urandom_range(0, 99);
         if (r < 4)
            issue_command(OP_ADD, ($urandom_range(0, 3) == 0) ? pick_hw() : rand_hw(),
                          ($urandom_range(0, 3) == 0) ? pick_net() : $urandom);
         else if (r < 48)
            issue_command(OP_LOOKUP, pick_hw(), $urandom);
         else if (r < 93)
            issue_command(OP_CHECK, rand_hw(), pick_net());
         else
            issue_command(OP_UNUSED, rand_hw(), $urandom);
      end

      // Full table: fill what is left, then adds must be rejected
      while (added_hw.size() < TABLE_DEPTH) issue_command(OP_ADD, rand_hw(), $urandom);
      repeat (3) issue_command(OP_ADD, rand_hw(), $urandom);
      issue_command(OP_LOOKUP, added_hw[TABLE_DEPTH - 1], '0);
      issue_command(OP_CHECK, '0, added_net[TABLE_DEPTH - 1]);

      // Wait out the last result words
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (outstanding != 0 && wait_cycles < 2000);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("tb_static_mac_ip_lease_table passed");
      else
         $display("tb_static_mac_ip_lease_table failed");
      $finish;
   end

   // Watchdog
   initial begin
      #400_000;
      $display("tb_static_mac_ip_lease_table failed");
      $finish;
   end

endmodule
